// ----- src/wsi_pkg.sv -----
package wsi_pkg;

    localparam int MAP_CELLS_DEF = 65536;
    localparam int MAX_STEPS_DEF = 64;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] STEP_INV_RST  = 32'd21845;
    localparam logic [31:0] CELL_INV_RST  = 32'd1310720;
    localparam logic [12:0] GRID_DIM_RST  = 13'd256;
    localparam logic [7:0]  THRESHOLD_RST = 8'd252;
    localparam logic signed [15:0] QUAT_ONE = 16'sd32767;

    // request operation codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_GOAL  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_INV  = 3'd0,
        CFG_ORIGIN_X  = 3'd1,
        CFG_ORIGIN_Y  = 3'd2,
        CFG_CELL_INV  = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5,
        CFG_THRESHOLD = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AR_MUL,
        AR_DIV,
        AR_SQRT
    } arith_mode_t;

    typedef enum logic [4:0] {
        UOP_IDLE, UOP_DIFF, UOP_SQX, UOP_SQY, UOP_SQRTD, UOP_SCALE,
        UOP_DIVW, UOP_SQRTW, UOP_DIVZ, UOP_SQRTZ, UOP_STEP, UOP_DIVX,
        UOP_DIVY, UOP_CELLX, UOP_CELLY, UOP_INDEX, UOP_READ, UOP_EMIT
    } uop_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQRTD, S_SCALE,
        S_DIVW, S_SQRTW, S_DIVZ, S_SQRTZ, S_STEP, S_DIVX,
        S_DIVY, S_CELLX, S_CELLY, S_INDEX, S_READ, S_EMIT
    } state_t;

    typedef struct packed {
        uop_t uop;
        logic start;
    } cmd_t;

    typedef struct packed {
        logic in_goal;
        logic arith_done;
        logic dist_zero;
        logic final_step;
        logic map_loaded;
        logic out_free;
    } status_t;

endpackage

// ----- src/wsi_if.sv -----
interface wsi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] cell_index;
    logic [7:0]  cell_cost;

    modport source (output valid, operation, pos_x, pos_y, cell_index, cell_cost,
                    input ready);
    modport sink (input valid, operation, pos_x, pos_y, cell_index, cell_cost,
                  output ready);
endinterface

interface wsi_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [15:0] orient_z;
    logic signed [15:0] orient_w;
    logic        point_free;
    logic        last_point;
    logic        steps_clipped;

    modport source (output valid, point_x, point_y, orient_z, orient_w, point_free,
                    last_point, steps_clipped, input ready);
    modport sink (input valid, point_x, point_y, orient_z, orient_w, point_free,
                  last_point, steps_clipped, output ready);
endinterface

// ----- src/wsi_arith.sv -----
module wsi_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  wsi_pkg::arith_mode_t mode,
    input  logic [67:0]          opa,
    input  logic [33:0]          opb,
    output logic [67:0]          result,
    output logic                 done
);
    import wsi_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    arith_mode_t mode_reg;
    logic [67:0] acc_reg;
    logic [67:0] sh_reg;
    logic [33:0] b_reg;
    logic [35:0] rem_reg;

    logic [67:0] mul_sum;
    logic [35:0] div_t;
    logic        div_ge;
    logic [35:0] sq_t;
    logic [35:0] trial;
    logic        sq_ge;

    assign mul_sum = acc_reg + sh_reg;
    assign div_t   = {rem_reg[34:0], sh_reg[63]};
    assign div_ge  = div_t >= {2'b00, b_reg};
    assign sq_t    = {rem_reg[33:0], sh_reg[65:64]};
    assign trial   = {acc_reg[33:0], 2'b01};
    assign sq_ge   = sq_t >= trial;

    assign result = acc_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            unique case (mode)
                AR_MUL:  cnt_reg <= 7'd34;
                AR_DIV:  cnt_reg <= 7'd64;
                AR_SQRT: cnt_reg <= 7'd33;
                default: cnt_reg <= 7'd34;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one multiplier bit, quotient bit or root bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            acc_reg  <= '0;
            sh_reg   <= opa;
            b_reg    <= opb;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            unique case (mode_reg)
                AR_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_reg <= mul_sum;
                    end
                    sh_reg <= {sh_reg[66:0], 1'b0};
                    b_reg  <= {1'b0, b_reg[33:1]};
                end
                AR_DIV:
                begin
                    rem_reg <= div_ge ? (div_t - {2'b00, b_reg}) : div_t;
                    acc_reg <= {acc_reg[66:0], div_ge};
                    sh_reg  <= {sh_reg[66:0], 1'b0};
                end
                AR_SQRT:
                begin
                    rem_reg <= sq_ge ? (sq_t - trial) : sq_t;
                    acc_reg <= {acc_reg[66:0], sq_ge};
                    sh_reg  <= {sh_reg[65:0], 2'b00};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("arith launched while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("arith done longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("arith done without a run");

endmodule

// ----- src/wsi_ctrl.sv -----
module wsi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  wsi_pkg::status_t status,
    output wsi_pkg::cmd_t    cmd
);
    import wsi_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   launched_reg;
    logic   launched_next;
    logic   unit_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (status.in_goal) state_next = S_DIFF;
            S_DIFF:  state_next = S_SQX;
            S_SQX:   if (status.arith_done) state_next = S_SQY;
            S_SQY:   if (status.arith_done) state_next = S_SQRTD;
            S_SQRTD: if (status.arith_done) state_next = S_SCALE;
            S_SCALE:
            begin
                if (status.arith_done)
                begin
                    state_next = status.dist_zero ? S_STEP : S_DIVW;
                end
            end
            S_DIVW:  if (status.arith_done) state_next = S_SQRTW;
            S_SQRTW: if (status.arith_done) state_next = S_DIVZ;
            S_DIVZ:  if (status.arith_done) state_next = S_SQRTZ;
            S_SQRTZ: if (status.arith_done) state_next = S_STEP;
            S_STEP:
            begin
                if (!status.final_step)
                begin
                    state_next = S_DIVX;
                end
                else
                begin
                    state_next = status.map_loaded ? S_CELLX : S_EMIT;
                end
            end
            S_DIVX:  if (status.arith_done) state_next = S_DIVY;
            S_DIVY:
            begin
                if (status.arith_done)
                begin
                    state_next = status.map_loaded ? S_CELLX : S_EMIT;
                end
            end
            S_CELLX: if (status.arith_done) state_next = S_CELLY;
            S_CELLY: if (status.arith_done) state_next = S_INDEX;
            S_INDEX: state_next = S_READ;
            S_READ:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.final_step ? S_IDLE : S_STEP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        unit_state = 1'b0;
        cmd.uop    = UOP_IDLE;
        unique case (state_reg)
            S_IDLE:  cmd.uop = UOP_IDLE;
            S_DIFF:  cmd.uop = UOP_DIFF;
            S_SQX:   begin cmd.uop = UOP_SQX;   unit_state = 1'b1; end
            S_SQY:   begin cmd.uop = UOP_SQY;   unit_state = 1'b1; end
            S_SQRTD: begin cmd.uop = UOP_SQRTD; unit_state = 1'b1; end
            S_SCALE: begin cmd.uop = UOP_SCALE; unit_state = 1'b1; end
            S_DIVW:  begin cmd.uop = UOP_DIVW;  unit_state = 1'b1; end
            S_SQRTW: begin cmd.uop = UOP_SQRTW; unit_state = 1'b1; end
            S_DIVZ:  begin cmd.uop = UOP_DIVZ;  unit_state = 1'b1; end
            S_SQRTZ: begin cmd.uop = UOP_SQRTZ; unit_state = 1'b1; end
            S_STEP:  cmd.uop = UOP_STEP;
            S_DIVX:  begin cmd.uop = UOP_DIVX;  unit_state = 1'b1; end
            S_DIVY:  begin cmd.uop = UOP_DIVY;  unit_state = 1'b1; end
            S_CELLX: begin cmd.uop = UOP_CELLX; unit_state = 1'b1; end
            S_CELLY: begin cmd.uop = UOP_CELLY; unit_state = 1'b1; end
            S_INDEX: cmd.uop = UOP_INDEX;
            S_READ:  cmd.uop = UOP_READ;
            S_EMIT:  cmd.uop = UOP_EMIT;
            default: cmd.uop = UOP_IDLE;
        endcase
        // launch the shared unit once on entry to a unit state
        cmd.start     = unit_state && !launched_reg;
        launched_next = (state_next != state_reg) ? 1'b0 : (launched_reg || cmd.start);
    end

endmodule

// ----- src/wsi_datapath.sv -----
module wsi_datapath #(
    parameter int MAP_CELLS = wsi_pkg::MAP_CELLS_DEF,
    parameter int MAX_STEPS = wsi_pkg::MAX_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wsi_pkg::cmd_t                   cmd,
    output wsi_pkg::status_t                status,
    wsi_in_if.sink                          request,
    wsi_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [wsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wsi_pkg::*;

    localparam int AW = $clog2(MAP_CELLS);
    localparam int SW = $clog2(MAX_STEPS + 1);

    // configuration
    logic [31:0]        step_inv_reg;
    logic signed [31:0] org_x_reg;
    logic signed [31:0] org_y_reg;
    logic [31:0]        cell_inv_reg;
    logic [12:0]        gw_reg;
    logic [12:0]        gh_reg;
    logic [7:0]         thr_reg;

    logic               map_loaded_reg;
    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic signed [31:0] goal_x_reg;
    logic signed [31:0] goal_y_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [65:0]        sum_reg;
    logic [33:0]        dist_reg;
    logic [SW-1:0]      steps_reg;
    logic               clip_reg;
    logic [30:0]        tq_reg;
    logic signed [15:0] z_reg;
    logic signed [15:0] w_reg;
    logic [SW-1:0]      i_reg;
    logic signed [39:0] accx_reg;
    logic signed [39:0] accy_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic               last_reg;
    logic [35:0]        qx_reg;
    logic [35:0]        qy_reg;
    logic               negx_reg;
    logic               negy_reg;
    logic [AW-1:0]      addr_reg;
    logic               blocked_reg;
    logic [7:0]         rd_reg;
    logic [7:0]         mem [MAP_CELLS];

    logic               out_valid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [15:0] out_z_reg;
    logic signed [15:0] out_w_reg;
    logic               out_free_reg;
    logic               out_last_reg;
    logic               out_clip_reg;

    logic               accept;
    logic               out_free;
    logic               emit_load;
    logic               final_step;
    logic               wr_ok;
    logic [AW-1:0]      wr_addr;

    logic [32:0]        ax;
    logic [32:0]        ay;
    logic signed [34:0] wnum;
    logic signed [34:0] znum;
    logic [39:0]        magax;
    logic [39:0]        magay;
    logic signed [32:0] dcx;
    logic signed [32:0] dcy;
    logic [32:0]        magcx;
    logic [32:0]        magcy;
    logic [35:0]        q_scale;
    logic [15:0]        root_sat;
    logic signed [33:0] sq_off;
    logic signed [33:0] new_p;
    logic [25:0]        row_base;
    logic [26:0]        cell_idx;
    logic               oob;

    arith_mode_t        ar_mode;
    logic [67:0]        ar_a;
    logic [33:0]        ar_b;
    logic [67:0]        ar_res;
    logic               ar_done;

    wsi_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .mode   (ar_mode),
        .opa    (ar_a),
        .opb    (ar_b),
        .result (ar_res),
        .done   (ar_done)
    );

    assign request.ready = (cmd.uop == UOP_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign emit_load     = (cmd.uop == UOP_EMIT) && out_free;
    assign final_step    = (SW'(i_reg + SW'(1)) == steps_reg);

    assign wr_ok   = {5'b0, request.cell_index} < 21'(MAP_CELLS);
    assign wr_addr = AW'(request.cell_index);

    assign ax    = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ay    = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign wnum  = $signed({1'b0, dist_reg}) + 35'(dx_reg);
    assign znum  = $signed({1'b0, dist_reg}) - 35'(dx_reg);
    assign magax = accx_reg[39] ? 40'(-accx_reg) : 40'(accx_reg);
    assign magay = accy_reg[39] ? 40'(-accy_reg) : 40'(accy_reg);
    assign dcx   = 33'(px_reg) - 33'(org_x_reg);
    assign dcy   = 33'(py_reg) - 33'(org_y_reg);
    assign magcx = dcx[32] ? 33'(-dcx) : 33'(dcx);
    assign magcy = dcy[32] ? 33'(-dcy) : 33'(dcy);
    assign q_scale  = ar_res[67:32];
    assign root_sat = (ar_res > 68'd32767) ? 16'd32767 : ar_res[15:0];

    // signed step offset for the axis being divided
    always_comb
    begin
        if (cmd.uop == UOP_DIVX)
        begin
            sq_off = accx_reg[39] ? -$signed({1'b0, ar_res[32:0]})
                                  : $signed({1'b0, ar_res[32:0]});
            new_p  = 34'(prev_x_reg) + sq_off;
        end
        else
        begin
            sq_off = accy_reg[39] ? -$signed({1'b0, ar_res[32:0]})
                                  : $signed({1'b0, ar_res[32:0]});
            new_p  = 34'(prev_y_reg) + sq_off;
        end
    end

    assign row_base = 26'(qy_reg[12:0]) * 26'(gw_reg);
    assign cell_idx = 27'(row_base) + 27'(qx_reg[12:0]);
    assign oob = negx_reg || negy_reg || (qx_reg >= 36'(gw_reg)) || (qy_reg >= 36'(gh_reg));

    always_comb
    begin
        ar_mode = AR_MUL;
        ar_a    = '0;
        ar_b    = '0;
        unique case (cmd.uop)
            UOP_SQX:   begin ar_a = 68'(ax); ar_b = 34'(ax); end
            UOP_SQY:   begin ar_a = 68'(ay); ar_b = 34'(ay); end
            UOP_SQRTD: begin ar_mode = AR_SQRT; ar_a = 68'(sum_reg); end
            UOP_SCALE: begin ar_a = 68'(dist_reg); ar_b = 34'(step_inv_reg); end
            UOP_DIVW:
            begin
                ar_mode = AR_DIV;
                ar_a    = 68'({wnum[33:0], 29'b0});
                ar_b    = dist_reg;
            end
            UOP_SQRTW: begin ar_mode = AR_SQRT; ar_a = 68'(tq_reg); end
            UOP_DIVZ:
            begin
                ar_mode = AR_DIV;
                ar_a    = 68'({znum[33:0], 29'b0});
                ar_b    = dist_reg;
            end
            UOP_SQRTZ: begin ar_mode = AR_SQRT; ar_a = 68'(tq_reg); end
            UOP_DIVX:  begin ar_mode = AR_DIV; ar_a = 68'(magax); ar_b = 34'(steps_reg); end
            UOP_DIVY:  begin ar_mode = AR_DIV; ar_a = 68'(magay); ar_b = 34'(steps_reg); end
            UOP_CELLX: begin ar_a = 68'(magcx); ar_b = 34'(cell_inv_reg); end
            UOP_CELLY: begin ar_a = 68'(magcy); ar_b = 34'(cell_inv_reg); end
            default:   ar_mode = AR_MUL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_inv_reg   <= STEP_INV_RST;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            cell_inv_reg   <= CELL_INV_RST;
            gw_reg         <= GRID_DIM_RST;
            gh_reg         <= GRID_DIM_RST;
            thr_reg        <= THRESHOLD_RST;
            map_loaded_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STEP_INV:  step_inv_reg <= cfg_data;
                    CFG_ORIGIN_X:  org_x_reg    <= cfg_data;
                    CFG_ORIGIN_Y:  org_y_reg    <= cfg_data;
                    CFG_CELL_INV:  cell_inv_reg <= cfg_data;
                    CFG_WIDTH:     gw_reg       <= cfg_data[12:0];
                    CFG_HEIGHT:    gh_reg       <= cfg_data[12:0];
                    CFG_THRESHOLD: thr_reg      <= cfg_data[7:0];
                    default:       thr_reg      <= thr_reg;
                endcase
            end
            if (accept && request.operation == OP_WRITE)
            begin
                map_loaded_reg <= 1'b1;
            end
            if (accept && request.operation == OP_START)
            begin
                prev_x_reg <= request.pos_x;
                prev_y_reg <= request.pos_y;
            end
            if (emit_load && last_reg)
            begin
                prev_x_reg <= goal_x_reg;
                prev_y_reg <= goal_y_reg;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && request.operation == OP_WRITE && wr_ok)
        begin
            mem[wr_addr] <= request.cell_cost;
        end
        if (cmd.uop == UOP_READ)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            goal_x_reg <= request.pos_x;
            goal_y_reg <= request.pos_y;
        end
        unique case (cmd.uop)
            UOP_DIFF:
            begin
                dx_reg   <= 33'(goal_x_reg) - 33'(prev_x_reg);
                dy_reg   <= 33'(goal_y_reg) - 33'(prev_y_reg);
                i_reg    <= '0;
                accx_reg <= '0;
                accy_reg <= '0;
            end
            UOP_SQX:   if (ar_done) sum_reg <= ar_res[65:0];
            UOP_SQY:   if (ar_done) sum_reg <= sum_reg + ar_res[65:0];
            UOP_SQRTD: if (ar_done) dist_reg <= ar_res[33:0];
            UOP_SCALE:
            begin
                if (ar_done)
                begin
                    z_reg <= '0;
                    w_reg <= QUAT_ONE;
                    if (q_scale == '0)
                    begin
                        steps_reg <= SW'(1);
                        clip_reg  <= 1'b0;
                    end
                    else if (q_scale > 36'(MAX_STEPS))
                    begin
                        steps_reg <= SW'(MAX_STEPS);
                        clip_reg  <= 1'b1;
                    end
                    else
                    begin
                        steps_reg <= SW'(q_scale);
                        clip_reg  <= 1'b0;
                    end
                end
            end
            UOP_DIVW:  if (ar_done) tq_reg <= ar_res[30:0];
            UOP_SQRTW: if (ar_done) w_reg <= $signed(root_sat);
            UOP_DIVZ:  if (ar_done) tq_reg <= ar_res[30:0];
            UOP_SQRTZ:
            begin
                if (ar_done)
                begin
                    z_reg <= dy_reg[32] ? -$signed(root_sat) : $signed(root_sat);
                end
            end
            UOP_STEP:
            begin
                i_reg    <= SW'(i_reg + SW'(1));
                last_reg <= final_step;
                accx_reg <= accx_reg + 40'(dx_reg);
                accy_reg <= accy_reg + 40'(dy_reg);
                if (final_step)
                begin
                    px_reg <= goal_x_reg;
                    py_reg <= goal_y_reg;
                end
            end
            UOP_DIVX:  if (ar_done) px_reg <= new_p[31:0];
            UOP_DIVY:  if (ar_done) py_reg <= new_p[31:0];
            UOP_CELLX:
            begin
                if (ar_done)
                begin
                    qx_reg   <= q_scale;
                    negx_reg <= dcx[32] && (q_scale != '0);
                end
            end
            UOP_CELLY:
            begin
                if (ar_done)
                begin
                    qy_reg   <= q_scale;
                    negy_reg <= dcy[32] && (q_scale != '0);
                end
            end
            UOP_INDEX:
            begin
                addr_reg    <= AW'(cell_idx);
                blocked_reg <= oob || ({1'b0, cell_idx} >= 28'(MAP_CELLS));
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
        if (emit_load)
        begin
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_z_reg    <= z_reg;
            out_w_reg    <= w_reg;
            out_free_reg <= !map_loaded_reg || (!blocked_reg && rd_reg < thr_reg);
            out_last_reg <= last_reg;
            out_clip_reg <= clip_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.point_x       = out_x_reg;
    assign result.point_y       = out_y_reg;
    assign result.orient_z      = out_z_reg;
    assign result.orient_w      = out_w_reg;
    assign result.point_free    = out_free_reg;
    assign result.last_point    = out_last_reg;
    assign result.steps_clipped = out_clip_reg;

    assign status.in_goal    = request.valid && (request.operation == OP_GOAL);
    assign status.arith_done = ar_done;
    assign status.dist_zero  = (dist_reg == '0);
    assign status.final_step = (cmd.uop == UOP_EMIT) ? last_reg : final_step;
    assign status.map_loaded = map_loaded_reg;
    assign status.out_free   = out_free;

endmodule

// ----- src/waypoint_segment_interpolator.sv -----
// goal request: segment setup first (shorter for a zero-length segment), then each point
//   in turn, with the grid read only when the map is loaded; the goal point skips the
//   two divides
// requests: one at a time; cell writes and start points are taken while idle
// all multiplies, divides and roots run through one shared bit-serial mul/div/sqrt unit
// reset: rst_n async active low; registers to defaults, map not loaded, prev = 0
module waypoint_segment_interpolator #(
    parameter int MAP_CELLS = wsi_pkg::MAP_CELLS_DEF,
    parameter int MAX_STEPS = wsi_pkg::MAX_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    wsi_in_if.sink                          request,
    wsi_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [wsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wsi_pkg::*;

    // controller sequences the micro-steps of a goal request:
    //   diff, squares, sqrt of distance, step count, two half-angle divides and roots
    //   unless the distance is zero, then per point: step, two divides by the step count
    //   (not for the goal point), with a loaded map two cell multiplies, index and grid read, then emit
    cmd_t    cmd;
    status_t status;

    wsi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath holds config, previous waypoint, cost grid memory and the
    // output register; the output register lets the next point be worked on
    // while the previous one still waits to be taken
    wsi_datapath #(
        .MAP_CELLS (MAP_CELLS),
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .request   (request),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
